// ===== hw/rtl/hte_pkg.sv =====
`default_nettype none

package hte_pkg;

  // Field widths of the channel words
  localparam int CMD_W        = 2;
  localparam int SYMBOL_W     = 8;
  localparam int CODE_FIELD_W = 16;
  localparam int LEN_FIELD_W  = 5;
  localparam int BYTE_W       = 8;
  localparam int VALID_W      = 4;

  // Bit accumulator: at most seven bits stay behind between encodes
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;

  // Defaults for the top-level parameters
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 16;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [VALID_W-1:0] valid_bits;
    logic               run_last;
    logic               stream_end;
  } result_t;

  // Up to two result words pushed by the packing stage in one cycle
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hte_if.sv =====
`default_nettype none

interface hte_in_if import hte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [SYMBOL_W-1:0]     symbol;
  logic [CODE_FIELD_W-1:0] code_bits;
  logic [LEN_FIELD_W-1:0]  code_length;

  modport source (output valid, command, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface hte_out_if import hte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [VALID_W-1:0] valid_bits;
  logic               run_last;
  logic               stream_end;

  modport source (output valid, out_byte, valid_bits, run_last, stream_end, input ready);
  modport sink   (input valid, out_byte, valid_bits, run_last, stream_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hte_out_queue.sv =====
`default_nettype none

module hte_out_queue import hte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire push_t    push,
  output logic          room,
  hte_out_if.source     out_chan
);

  result_t            q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr_p1;
  result_t            head;

  assign room      = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_chan.valid && out_chan.ready;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);
  assign head      = q_r[rd_ptr_r];

  assign out_chan.valid      = (count_r != '0);
  assign out_chan.out_byte   = head.out_byte;
  assign out_chan.valid_bits = head.valid_bits;
  assign out_chan.run_last   = head.run_last;
  assign out_chan.stream_end = head.stream_end;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots carry no reset
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      q_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_table_encoder_bit_packer_top.sv =====
`default_nettype none

// Channel   Dir  Word fields                                      Handshake
// in_chan   in   command, symbol, code_bits, code_length          valid/ready
// out_chan  out  out_byte, valid_bits, run_last, stream_end       valid/ready
//
// One input word is taken per cycle. The code table sits in a single-port
// synchronous RAM: a word is looked up at the edge it is accepted and packed
// from the registered entry, where it waits while the queue lacks room.
// An encode that fills two bytes pushes both into the queue at once; a
// four-entry result queue between packing and output absorbs this, and input
// stalls only while that queue has less than two free slots.
// Reset clears the bit accumulator, the pipeline and the queue; the table is
// not cleared and each entry must be loaded before it is encoded.

module huffman_table_encoder_bit_packer_top import hte_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hte_in_if.sink    in_chan,
  hte_out_if.source out_chan
);

  // Stored code length saturates at the smaller of the parameter and the field
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int ENT_W   = LEN_CAP + LEN_W;
  localparam int ACC_W   = PEND_W + LEN_CAP;
  localparam int TOT_W   = $clog2(ACC_W + 1);

  // ---------------------------------------------------------------- lookup
  logic [ENT_W-1:0]  table_mem [SYMBOL_COUNT];
  logic [ENT_W-1:0]  rd_entry_r;

  logic              in_fire;
  cmd_t              in_cmd;
  logic              in_sym_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  ld_len;
  logic [LEN_CAP-1:0] ld_code;

  logic              s1_valid_r, s1_valid_nxt;
  cmd_t              s1_cmd_r;
  logic              s1_sym_ok_r;
  logic              s1_adv;
  logic              q_room;

  assign in_cmd    = cmd_t'(in_chan.command);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign in_sym_ok = ({1'b0, in_chan.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
  assign in_addr   = in_chan.symbol[ADDR_W-1:0];

  // Accept while the packing stage is empty or moves on this cycle
  assign in_chan.ready = !s1_valid_r || q_room;
  assign s1_adv        = s1_valid_r && q_room;

  // Clamp the length and drop code bits above it before they are stored
  always_comb begin
    if (in_chan.code_length > LEN_FIELD_W'(LEN_CAP)) begin
      ld_len = LEN_W'(LEN_CAP);
    end else begin
      ld_len = LEN_W'(in_chan.code_length);
    end
    ld_code = in_chan.code_bits[LEN_CAP-1:0] & ~({LEN_CAP{1'b1}} << ld_len);
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_LOAD) && in_sym_ok) begin
      table_mem[in_addr] <= {ld_code, ld_len};
    end
    if (in_fire) begin
      rd_entry_r <= table_mem[in_addr];
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r    <= in_cmd;
      s1_sym_ok_r <= in_sym_ok;
    end
  end

  // --------------------------------------------------------------- packing
  logic [PEND_W-1:0]  pbits_r, pbits_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [LEN_W-1:0]   e_len;
  logic [LEN_CAP-1:0] e_code;
  logic [ACC_W-1:0]   acc;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   rem;
  logic [TOT_W-1:0]   sh0, sh1;
  logic [BYTE_W-1:0]  flush_byte;
  push_t              push;

  assign e_len  = rd_entry_r[LEN_W-1:0];
  assign e_code = rd_entry_r[ENT_W-1:LEN_W];
  assign acc    = (ACC_W'(pbits_r) << e_len) | ACC_W'(e_code);
  assign total  = TOT_W'(pcnt_r) + TOT_W'(e_len);
  assign sh0    = total - TOT_W'(BYTE_W);
  assign sh1    = total - TOT_W'(2 * BYTE_W);
  assign flush_byte = BYTE_W'({1'b0, pbits_r}) << (VALID_W'(BYTE_W) - VALID_W'(pcnt_r));

  always_comb begin
    pbits_nxt   = pbits_r;
    pcnt_nxt    = pcnt_r;
    rem         = total;
    push.num    = 2'd0;
    push.first  = '0;
    push.second = '0;

    if (s1_adv) begin
      unique case (s1_cmd_r)
        CMD_ENCODE: begin
          if (s1_sym_ok_r && (e_len != '0)) begin
            if (total >= TOT_W'(2 * BYTE_W)) begin
              rem         = sh1;
              push.num    = 2'd2;
              push.first  = '{out_byte: BYTE_W'(acc >> sh0), valid_bits: VALID_W'(BYTE_W),
                              run_last: 1'b0, stream_end: 1'b0};
              push.second = '{out_byte: BYTE_W'(acc >> sh1), valid_bits: VALID_W'(BYTE_W),
                              run_last: 1'b1, stream_end: 1'b0};
            end else if (total >= TOT_W'(BYTE_W)) begin
              rem         = sh0;
              push.num    = 2'd1;
              push.first  = '{out_byte: BYTE_W'(acc >> sh0), valid_bits: VALID_W'(BYTE_W),
                              run_last: 1'b1, stream_end: 1'b0};
            end
            // Keep only the bits not yet emitted, right aligned
            pbits_nxt = PEND_W'(acc & ~({ACC_W{1'b1}} << rem));
            pcnt_nxt  = PCNT_W'(rem);
          end
        end
        CMD_FLUSH: begin
          push.num   = 2'd1;
          push.first = '{out_byte: flush_byte, valid_bits: VALID_W'(pcnt_r),
                         run_last: 1'b1, stream_end: 1'b1};
          pbits_nxt  = '0;
          pcnt_nxt   = '0;
        end
        CMD_LOAD, CMD_NONE: begin
          // no result, accumulator untouched
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r <= '0;
      pcnt_r  <= '0;
    end else begin
      pbits_r <= pbits_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  hte_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (q_room),
    .out_chan (out_chan)
  );

  // ------------------------------------------------------------ assertions
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_cmd_r == CMD_FLUSH)) |=> (pcnt_r == '0) && (pbits_r == '0))
    else $error("accumulator not cleared after flush");

  a_stall_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(rd_entry_r) && $stable(s1_cmd_r))
    else $error("looked-up entry changed while packing stage stalled");

  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ((pbits_r >> pcnt_r) == '0))
    else $error("stray accumulator bits above pending count");

  a_no_push_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_adv) |-> (push.num == 2'd0))
    else $error("result pushed without stage advance");

endmodule

`default_nettype wire

// ===== dv/hte_checker.sv =====
`timescale 1ns / 1ps

module hte_checker import hte_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hte_in_if           in_mon,
  hte_out_if          out_mon,
  output int unsigned error_count,
  output int unsigned bytes_owed
);

  localparam int LEN_CAP = (MAX_CODE_LEN_DEF < CODE_FIELD_W) ? MAX_CODE_LEN_DEF : CODE_FIELD_W;

  logic [CODE_FIELD_W-1:0] tbl_code [SYMBOL_COUNT_DEF];
  logic [LEN_FIELD_W-1:0]  tbl_len  [SYMBOL_COUNT_DEF];
  logic [PEND_W-1:0]       acc_bits;
  logic [PCNT_W-1:0]       acc_count;
  result_t                 expected_bytes [$];
  int unsigned             errors = 0;
  int unsigned             owed = 0;

  assign error_count = errors;
  assign bytes_owed  = owed;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Update the table and bit accumulator for one accepted word; queue its bytes.
  task automatic predict_word(input cmd_t cmd, input logic [SYMBOL_W-1:0] sym,
                              input logic [CODE_FIELD_W-1:0] code,
                              input logic [LEN_FIELD_W-1:0] len);
    logic [LEN_FIELD_W-1:0] eff_len;
    logic [31:0]            acc;
    logic [31:0]            sh;
    logic [31:0]            mask;
    int                     total;
    result_t                r;
    case (cmd)
      CMD_LOAD: begin
        if (int'(sym) < SYMBOL_COUNT_DEF) begin
          eff_len = (int'(len) > LEN_CAP) ? LEN_FIELD_W'(LEN_CAP) : len;
          mask = (32'd1 << eff_len) - 32'd1;
          tbl_len[sym]  = eff_len;
          tbl_code[sym] = code & mask[CODE_FIELD_W-1:0];
        end
      end
      CMD_ENCODE: begin
        if (int'(sym) < SYMBOL_COUNT_DEF && tbl_len[sym] != '0) begin
          acc   = (32'(acc_bits) << tbl_len[sym]) | 32'(tbl_code[sym]);
          total = int'(acc_count) + int'(tbl_len[sym]);
          while (total >= 8) begin
            total -= 8;
            sh = acc >> total;
            r.out_byte   = sh[BYTE_W-1:0];
            r.valid_bits = VALID_W'(8);
            r.run_last   = (total < 8);
            r.stream_end = 1'b0;
            expected_bytes.push_back(r);
          end
          mask      = (32'd1 << total) - 32'd1;
          acc_bits  = PEND_W'(acc & mask);
          acc_count = PCNT_W'(total);
        end
      end
      CMD_FLUSH: begin
        sh = 32'(acc_bits) << (8 - int'(acc_count));
        r.out_byte   = sh[BYTE_W-1:0];
        r.valid_bits = VALID_W'(acc_count);
        r.run_last   = 1'b1;
        r.stream_end = 1'b1;
        expected_bytes.push_back(r);
        acc_bits  = '0;
        acc_count = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_byte();
    result_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected: byte %02h valid %0d last %0b end %0b",
                                out_mon.out_byte, out_mon.valid_bits, out_mon.run_last,
                                out_mon.stream_end));
      return;
    end
    want = expected_bytes.pop_front();
    if (out_mon.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, expected %02h", out_mon.out_byte, want.out_byte));
    if (out_mon.valid_bits !== want.valid_bits)
      report_mismatch($sformatf("valid_bits %0d, expected %0d",
                                out_mon.valid_bits, want.valid_bits));
    if (out_mon.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %0b, expected %0b", out_mon.run_last, want.run_last));
    if (out_mon.stream_end !== want.stream_end)
      report_mismatch($sformatf("stream_end %0b, expected %0b",
                                out_mon.stream_end, want.stream_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_bits  = '0;
      acc_count = '0;
      expected_bytes.delete();
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_byte();
      if (in_mon.valid && in_mon.ready)
        predict_word(cmd_t'(in_mon.command), in_mon.symbol, in_mon.code_bits,
                     in_mon.code_length);
    end
    owed <= expected_bytes.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hte_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  hte_in_if  in_chan();
  hte_out_if out_chan();

  int unsigned error_count;
  int unsigned bytes_owed;

  // Symbols whose table entry has been written; only these get encoded
  bit                  loaded [SYMBOL_COUNT_DEF];
  logic [SYMBOL_W-1:0] loaded_syms [$];

  // When set, the sender pushes words back to back
  bit burst_mode = 1'b0;

  huffman_table_encoder_bit_packer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hte_checker pack_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .error_count (error_count),
    .bytes_owed  (bytes_owed)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle cycles before a word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word and hold it until accepted. Ready is sampled at the
  // falling edge, where it is stable up to the next rising edge, so the
  // task returns in the time step of the accepting edge.
  task automatic send_word(input cmd_t cmd, input logic [SYMBOL_W-1:0] sym,
                           input logic [CODE_FIELD_W-1:0] code,
                           input logic [LEN_FIELD_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.command     <= cmd;
    in_chan.symbol      <= sym;
    in_chan.code_bits   <= code;
    in_chan.code_length <= len;
    do @(negedge clk); while (!in_chan.ready);
    @(posedge clk);
    // Track written entries so that no unwritten one is ever encoded
    if (cmd == CMD_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Drop valid and hold off until every predicted byte has left the block.
  // It steps past a rising edge first, so the count includes the word accepted
  // in this time step.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
  endtask

  // Result side: stretches of ready high, short stalls, and a few long ones.
  initial begin : out_ready_drive
    int  r;
    int  n;
    bit  val;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        val = 1'b1;
        n   = $urandom_range(1, 30);
      end else if (r < 18) begin
        val = 1'b0;
        n   = $urandom_range(1, 3);
      end else begin
        val = 1'b0;
        n   = $urandom_range(10, 40);
      end
      out_chan.ready <= val;
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                      r;
    int                      lr;
    logic [LEN_FIELD_W-1:0]  len;
    logic [SYMBOL_W-1:0]     sym;

    in_chan.valid       <= 1'b0;
    in_chan.command     <= CMD_NONE;
    in_chan.symbol      <= '0;
    in_chan.code_bits   <= '0;
    in_chan.code_length <= '0;

    // Hold reset, then release
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ---- Directed words ----
    // Flush with nothing pending: one empty stream-end byte
    send_word(CMD_FLUSH, 8'h00, 16'h0000, 5'd0);
    // Unused command with all field bits set: must be dropped
    send_word(CMD_NONE, 8'hFF, 16'hFFFF, 5'd31);
    // Table entries: longest code, lowest and highest index, saturating
    // length, code bits above the length, zero length, exact byte
    send_word(CMD_LOAD, 8'h00, 16'hFFFF, 5'd16);
    send_word(CMD_LOAD, 8'hFF, 16'h0000, 5'd1);
    send_word(CMD_LOAD, 8'h01, 16'hABCD, 5'd31);
    send_word(CMD_LOAD, 8'h02, 16'hFFFF, 5'd3);
    send_word(CMD_LOAD, 8'h03, 16'h1234, 5'd0);
    send_word(CMD_LOAD, 8'h04, 16'h0005, 5'd8);
    // 16-bit code from an empty accumulator: two full bytes
    send_word(CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
    // One bit pending, then 16 more: two bytes with one bit left over
    send_word(CMD_ENCODE, 8'hFF, 16'h0000, 5'd0);
    send_word(CMD_ENCODE, 8'h01, 16'h0000, 5'd0);
    // Zero-length entry: no bytes at all
    send_word(CMD_ENCODE, 8'h03, 16'h0000, 5'd0);
    // Three masked bits on top, then flush a four-bit partial byte
    send_word(CMD_ENCODE, 8'h02, 16'h0000, 5'd0);
    send_word(CMD_FLUSH, 8'h00, 16'h0000, 5'd0);
    // Exactly eight bits: one byte, nothing pending, then an empty flush
    send_word(CMD_ENCODE, 8'h04, 16'h0000, 5'd0);
    send_word(CMD_FLUSH, 8'h00, 16'h0000, 5'd0);
    // Build seven pending bits and flush them
    send_word(CMD_ENCODE, 8'h02, 16'h0000, 5'd0);
    send_word(CMD_ENCODE, 8'h02, 16'h0000, 5'd0);
    send_word(CMD_ENCODE, 8'hFF, 16'h0000, 5'd0);
    send_word(CMD_FLUSH, 8'h00, 16'h0000, 5'd0);
    // Three pending plus sixteen: two bytes, three bits left
    send_word(CMD_ENCODE, 8'h02, 16'h0000, 5'd0);
    send_word(CMD_ENCODE, 8'h00, 16'h0000, 5'd0);
    send_word(CMD_FLUSH, 8'h00, 16'h0000, 5'd0);

    // ---- Random words ----
    // Mostly encodes of written entries, some loads, a few flushes, and
    // the odd unused command dropped in as noise.
    for (int i = 0; i < 270; i++) begin
      if (i % 40 == 0)
        burst_mode = ($urandom_range(0, 2) == 0);
      // Stop feeding once until the block has emptied
      if (i == 135)
        wait_drained();
      r = $urandom_range(0, 99);
      if (r >= 96)
        send_word(CMD_NONE, SYMBOL_W'($urandom), CODE_FIELD_W'($urandom),
                  LEN_FIELD_W'($urandom));
      if (r < 14 || loaded_syms.size() == 0) begin
        lr = $urandom_range(0, 19);
        if (lr == 0)
          len = '0;
        else if (lr < 17)
          len = LEN_FIELD_W'($urandom_range(1, 16));
        else
          len = LEN_FIELD_W'($urandom_range(17, 31));
        send_word(CMD_LOAD, SYMBOL_W'($urandom), CODE_FIELD_W'($urandom), len);
      end else if (r < 90) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        // Load-only fields carry junk on encodes; the block must ignore them
        send_word(CMD_ENCODE, sym, CODE_FIELD_W'($urandom), LEN_FIELD_W'($urandom));
      end else begin
        send_word(CMD_FLUSH, SYMBOL_W'($urandom), CODE_FIELD_W'($urandom),
                  LEN_FIELD_W'($urandom));
      end
    end

    // Drop valid, drain, and give the block time to show any stray byte
    in_chan.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    if (error_count == 0 && bytes_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
